### hdl/stunbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stunbr_pkg
// shared constants and widths for the stun binding response parser
// ----------------------------------------------------------------------------
package stunbr_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 104;

    localparam logic [4:0]  HDR_LAST_IDX = 5'd19;
    localparam logic [3:0]  REC_LAST_IDX = 4'd11;

    localparam logic [15:0] KIND_BIND_RESP = 16'h0101;
    localparam logic [15:0] KIND_MAPPED    = 16'h0001;
    localparam logic [15:0] KIND_SOURCE    = 16'h0004;
    localparam logic [15:0] KIND_CHANGED   = 16'h0005;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_ATTR   = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_REJECT = 3'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_BIND = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_CUT      = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;

endpackage

### hdl/stun_binding_response_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stun_binding_response_parser
// byte-wide parser of a stun binding response, one result per message
// ----------------------------------------------------------------------------
// channel  dir  width  contents
// s_       in   8+1    tdata: data_byte[7:0]; tlast: last_byte
// m_       out  104    tdata: status, mapped_found, mapped_ip, mapped_port,
//                      changed_found, changed_ip, changed_port, zero pad
//
// one byte accepted per cycle while s_tready is high; the result is registered
// and is in the output register in the cycle after the final byte is accepted
// s_tready is low only while a result waits in the output register
// aresetn is synchronous and active low; state returns to header phase
// after every final byte
// ----------------------------------------------------------------------------
module stun_binding_response_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [stunbr_pkg::S_TDATA_W-1:0] s_tdata,  // data_byte[7:0]
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[2:0] mapped_found[3] mapped_ip[35:4] mapped_port[51:36]
    // changed_found[52] changed_ip[84:53] changed_port[100:85] pad[103:101]
    output logic [stunbr_pkg::M_TDATA_W-1:0] m_tdata
);
    import stunbr_pkg::*;

    logic [4:0]  hdr_cnt_reg,  hdr_cnt_next;
    logic [15:0] msg_kind_reg, msg_kind_next;
    logic [2:0]  phase_reg,    phase_next;
    logic [3:0]  rec_idx_reg,  rec_idx_next;
    logic [15:0] rec_kind_reg, rec_kind_next;
    logic [15:0] rec_port_reg, rec_port_next;
    logic [31:0] rec_addr_reg, rec_addr_next;
    logic [31:0] map_ip_reg,   map_ip_next;
    logic [15:0] map_port_reg, map_port_next;
    logic        map_seen_reg, map_seen_next;
    logic [31:0] chg_ip_reg,   chg_ip_next;
    logic [15:0] chg_port_reg, chg_port_next;
    logic        chg_seen_reg, chg_seen_next;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg,  m_data_next;

    logic        accept;
    logic [7:0]  b;
    logic [2:0]  status;
    logic        report;
    logic [15:0] kind_upd, port_upd;
    logic [31:0] addr_upd;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata[7:0];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign kind_upd = (rec_idx_reg < 4'd2) ? {rec_kind_reg[7:0], b} : rec_kind_reg;
    assign port_upd = (rec_idx_reg == 4'd6 || rec_idx_reg == 4'd7)
                      ? {rec_port_reg[7:0], b} : rec_port_reg;
    assign addr_upd = (rec_idx_reg >= 4'd8) ? {rec_addr_reg[23:0], b} : rec_addr_reg;

    always_comb begin
        hdr_cnt_next  = hdr_cnt_reg;
        msg_kind_next = msg_kind_reg;
        phase_next    = phase_reg;
        rec_idx_next  = rec_idx_reg;
        rec_kind_next = rec_kind_reg;
        rec_port_next = rec_port_reg;
        rec_addr_next = rec_addr_reg;
        map_ip_next   = map_ip_reg;
        map_port_next = map_port_reg;
        map_seen_next = map_seen_reg;
        chg_ip_next   = chg_ip_reg;
        chg_port_next = chg_port_reg;
        chg_seen_next = chg_seen_reg;
        status        = ST_OK;
        report        = 1'b1;

        unique case (phase_reg)
            PH_HEADER: begin
                if (hdr_cnt_reg < 5'd2) begin
                    msg_kind_next = {msg_kind_reg[7:0], b};
                end
                if (hdr_cnt_reg == HDR_LAST_IDX) begin
                    hdr_cnt_next = '0;
                    if (msg_kind_next == KIND_BIND_RESP) begin
                        phase_next = PH_ATTR;
                    end else begin
                        phase_next = PH_REJECT;
                        status     = ST_NOT_BIND;
                        report     = 1'b0;
                    end
                end else begin
                    hdr_cnt_next = hdr_cnt_reg + 5'd1;
                    status       = ST_SHORT;
                    report       = 1'b0;
                end
            end
            PH_REJECT: begin
                status = ST_NOT_BIND;
                report = 1'b0;
            end
            PH_SKIP: begin
                status = ST_UNKNOWN;
            end
            PH_ATTR: begin
                rec_kind_next = kind_upd;
                rec_port_next = port_upd;
                rec_addr_next = addr_upd;
                if (rec_idx_reg == 4'd1 && kind_upd != KIND_MAPPED &&
                    kind_upd != KIND_SOURCE && kind_upd != KIND_CHANGED) begin
                    phase_next = PH_SKIP;
                    status     = ST_UNKNOWN;
                end else if (rec_idx_reg >= REC_LAST_IDX) begin
                    if (kind_upd == KIND_MAPPED) begin
                        map_ip_next   = addr_upd;
                        map_port_next = port_upd;
                        map_seen_next = 1'b1;
                    end else if (kind_upd == KIND_CHANGED) begin
                        chg_ip_next   = addr_upd;
                        chg_port_next = port_upd;
                        chg_seen_next = 1'b1;
                    end
                    rec_idx_next  = '0;
                    rec_kind_next = '0;
                    rec_port_next = '0;
                    rec_addr_next = '0;
                end else begin
                    rec_idx_next = rec_idx_reg + 4'd1;
                    status       = ST_CUT;
                end
            end
            default: begin
                status = ST_NOT_BIND;
                report = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept && s_tlast) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_data_next[2:0] = status;
            if (report) begin
                m_data_next[3]      = map_seen_next;
                m_data_next[35:4]   = map_ip_next;
                m_data_next[51:36]  = map_port_next;
                m_data_next[52]     = chg_seen_next;
                m_data_next[84:53]  = chg_ip_next;
                m_data_next[100:85] = chg_port_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            hdr_cnt_reg  <= '0;
            msg_kind_reg <= '0;
            phase_reg    <= PH_HEADER;
            rec_idx_reg  <= '0;
            rec_kind_reg <= '0;
            rec_port_reg <= '0;
            rec_addr_reg <= '0;
            map_ip_reg   <= '0;
            map_port_reg <= '0;
            map_seen_reg <= 1'b0;
            chg_ip_reg   <= '0;
            chg_port_reg <= '0;
            chg_seen_reg <= 1'b0;
        end else if (accept) begin
            hdr_cnt_reg  <= hdr_cnt_next;
            msg_kind_reg <= msg_kind_next;
            phase_reg    <= phase_next;
            rec_idx_reg  <= rec_idx_next;
            rec_kind_reg <= rec_kind_next;
            rec_port_reg <= rec_port_next;
            rec_addr_reg <= rec_addr_next;
            map_ip_reg   <= map_ip_next;
            map_port_reg <= map_port_next;
            map_seen_reg <= map_seen_next;
            chg_ip_reg   <= chg_ip_next;
            chg_port_reg <= chg_port_next;
            chg_seen_reg <= chg_seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

endmodule

### hdl/stunbr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stunbr_checker
// port-level checks on the result channel of the parser
// ----------------------------------------------------------------------------
module stunbr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [stunbr_pkg::M_TDATA_W-1:0] m_tdata
);
    import stunbr_pkg::*;

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // rejected or short messages report nothing
    a_reject_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == ST_NOT_BIND || m_tdata[2:0] == ST_SHORT)
        |-> m_tdata[M_TDATA_W-1:3] == '0)
        else $error("rejected message carries addresses");

    // address fields zero unless found
    a_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3] || m_tdata[51:4] == '0) &&
                     (m_tdata[52] || m_tdata[100:53] == '0) &&
                     m_tdata[103:101] == '0)
        else $error("address without found flag");

    // input is taken whenever the output register is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind stun_binding_response_parser stunbr_checker u_stunbr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
